// ===== src/uart_16550_register_block_core_assert.svh =====
// ----------------------------------------------------------------------------
// UART 16550 register block - assertion macros
// Concurrent checks clocked on clk and disabled during rst. The macros leave
// no logic behind when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef UART_16550_REGISTER_BLOCK_CORE_ASSERT_SVH
`define UART_16550_REGISTER_BLOCK_CORE_ASSERT_SVH

`ifndef SYNTH

// Condition that holds at every clock edge outside reset
`define U16550_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("u16550 check failed");

// Condition that implies a consequence on the next clock edge
`define U16550_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u16550 check failed");

`else

`define U16550_ASSERT_ALWAYS(lbl, cond)
`define U16550_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== src/u16550_pkg.sv =====
// ----------------------------------------------------------------------------
// u16550_pkg
// Types, register offsets and fixed codes shared by the 16550 register block.
// ----------------------------------------------------------------------------
package u16550_pkg;

  // Request kinds
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_RX    = 2'd2;

  // Register offsets
  localparam logic [2:0] REG_RBR = 3'd0;
  localparam logic [2:0] REG_IER = 3'd1;
  localparam logic [2:0] REG_IIR = 3'd2;
  localparam logic [2:0] REG_LCR = 3'd3;
  localparam logic [2:0] REG_MCR = 3'd4;
  localparam logic [2:0] REG_LSR = 3'd5;
  localparam logic [2:0] REG_MSR = 3'd6;
  localparam logic [2:0] REG_SCR = 3'd7;

  // Interrupt identification codes
  localparam logic [7:0] IIR_RLS      = 8'h06;
  localparam logic [7:0] IIR_RDA      = 8'h04;
  localparam logic [7:0] IIR_TX_EMPTY = 8'h02;
  localparam logic [7:0] IIR_NONE     = 8'h01;

  // Fixed values
  localparam logic [7:0]  LCR_RESET      = 8'h03;
  localparam logic [15:0] DIV_RESET      = 16'd54;
  localparam logic [7:0]  LSR_TX_IDLE    = 8'h60;
  localparam int          LCR_DIV_ACCESS = 7;
  localparam int          FCR_RXCLR      = 1;

  // Line format codes
  localparam logic [1:0] STOP_ONE      = 2'd0;
  localparam logic [1:0] STOP_ONE_HALF = 2'd1;
  localparam logic [1:0] STOP_TWO      = 2'd2;
  localparam logic [2:0] PAR_NONE  = 3'd0;
  localparam logic [2:0] PAR_ODD   = 3'd1;
  localparam logic [2:0] PAR_EVEN  = 3'd2;
  localparam logic [2:0] PAR_MARK  = 3'd3;
  localparam logic [2:0] PAR_SPACE = 3'd4;

  // One input item
  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] reg_offset;
    logic [7:0] write_byte;
    logic [7:0] rx_char;
    logic       rx_parity_ok;
  } item_t;

  // One result item; rx_pop marks that read_byte comes from the FIFO memory
  typedef struct packed {
    logic        rx_pop;
    logic [7:0]  read_byte;
    logic        irq_line;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [15:0] baud_divisor;
    logic [3:0]  word_bits;
    logic [1:0]  stop_code;
    logic [2:0]  parity_code;
  } res_t;

endpackage

// ===== src/u16550_rx_mem.sv =====
// ----------------------------------------------------------------------------
// u16550_rx_mem
// Receive FIFO storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module u16550_rx_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // Store a received character
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read the oldest character; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/u16550_regs.sv =====
// ----------------------------------------------------------------------------
// u16550_regs
// Register file and FIFO pointers: decode one item, update state and form
// the result fields. FIFO data moves through the external memory ports.
// ----------------------------------------------------------------------------
module u16550_regs
  import u16550_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  item_t         item,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  output res_t          res,
  output logic          mem_wr_en,
  output logic [AW-1:0] mem_wr_addr,
  output logic [7:0]    mem_wr_data,
  output logic          mem_rd_en,
  output logic [AW-1:0] mem_rd_addr
);

  localparam logic [AW:0]   DEPTH_P = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [15:0]   dflt_div;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [15:0]   div, div_next;
  logic [7:0]    lcr, lcr_next;
  logic [3:0]    ier, ier_next;
  logic [1:0]    err, err_next;
  logic          thre, thre_next;
  logic [7:0]    mcr, mcr_next;
  logic [7:0]    msr, msr_next;
  logic [7:0]    scr, scr_next;

  logic [15:0] reload_div;
  logic [AW:0] head_inc;
  logic [AW:0] tail_sum;
  logic [AW-1:0] tail;
  logic [15:0] div_wr;
  logic        dlab;

  // Pointer arithmetic: wrap at the FIFO depth
  always_comb begin
    head_inc = {1'b0, head} + (AW+1)'(1);
    tail_sum = {1'b0, head} + (AW+1)'(count);
    if (tail_sum >= DEPTH_P) begin
      tail = AW'(tail_sum - DEPTH_P);
    end else begin
      tail = tail_sum[AW-1:0];
    end
    reload_div = (dflt_div == 16'd0) ? 16'd1 : dflt_div;
    dlab       = lcr[LCR_DIV_ACCESS];
  end

  // Decode the item and compute the next state
  always_comb begin
    head_next  = head;
    count_next = count;
    div_next   = div;
    lcr_next   = lcr;
    ier_next   = ier;
    err_next   = err;
    thre_next  = thre;
    mcr_next   = mcr;
    msr_next   = msr;
    scr_next   = scr;
    div_wr     = div;

    res.rx_pop    = 1'b0;
    res.read_byte = 8'd0;
    res.tx_valid  = 1'b0;
    res.tx_byte   = 8'd0;

    mem_wr_en   = 1'b0;
    mem_wr_addr = tail;
    mem_wr_data = item.rx_char;
    mem_rd_addr = head;

    unique case (item.req_type)
      REQ_READ: begin
        unique case (item.reg_offset)
          REG_RBR: begin
            if (dlab) begin
              res.read_byte = div[7:0];
            end else if (count != '0) begin
              res.rx_pop = 1'b1;
              count_next = count - CW'(1);
              head_next  = (head_inc == DEPTH_P) ? '0 : head_inc[AW-1:0];
            end
          end
          REG_IER: res.read_byte = dlab ? div[15:8] : {4'd0, ier};
          REG_IIR: begin
            if (err != 2'd0) begin
              res.read_byte = IIR_RLS;
            end else if (count != '0) begin
              res.read_byte = IIR_RDA;
            end else if (thre) begin
              res.read_byte = IIR_TX_EMPTY;
              thre_next     = 1'b0;
            end else begin
              res.read_byte = IIR_NONE;
            end
          end
          REG_LCR: res.read_byte = lcr;
          REG_MCR: res.read_byte = mcr;
          REG_LSR: begin
            res.read_byte = LSR_TX_IDLE | {5'd0, err, (count != '0)};
            err_next      = 2'd0;
          end
          REG_MSR: res.read_byte = msr;
          REG_SCR: res.read_byte = scr;
          default: res.read_byte = 8'd0;
        endcase
      end
      REQ_WRITE: begin
        unique case (item.reg_offset)
          REG_RBR: begin
            if (dlab) begin
              div_wr   = {div[15:8], item.write_byte};
              div_next = (div_wr == 16'd0) ? reload_div : div_wr;
            end else begin
              res.tx_valid = 1'b1;
              res.tx_byte  = item.write_byte;
              thre_next    = 1'b1;
            end
          end
          REG_IER: begin
            if (dlab) begin
              div_wr   = {item.write_byte, div[7:0]};
              div_next = (div_wr == 16'd0) ? reload_div : div_wr;
            end else begin
              ier_next = item.write_byte[3:0];
            end
          end
          REG_IIR: begin
            if (item.write_byte[FCR_RXCLR]) begin
              count_next = '0;
              head_next  = '0;
            end
          end
          REG_LCR: lcr_next = item.write_byte;
          REG_MCR: mcr_next = item.write_byte;
          REG_LSR: ;
          REG_MSR: msr_next = item.write_byte;
          REG_SCR: scr_next = item.write_byte;
          default: ;
        endcase
      end
      REQ_RX: begin
        if (count < DEPTH_C) begin
          mem_wr_en  = 1'b1;
          count_next = count + CW'(1);
          if (!item.rx_parity_ok) begin
            err_next[1] = 1'b1;
          end
        end else begin
          err_next[0] = 1'b1;
        end
      end
      default: ;
    endcase

    mem_wr_en = mem_wr_en & go;
    mem_rd_en = res.rx_pop & go;

    // Status and line format seen after the item
    res.irq_line = (ier_next[0] & (count_next != '0)) |
                   (ier_next[1] & thre_next) |
                   (ier_next[2] & (err_next != 2'd0));
    res.baud_divisor = div_next;
    res.word_bits    = 4'd5 + {2'd0, lcr_next[1:0]};
    if (!lcr_next[2]) begin
      res.stop_code = STOP_ONE;
    end else if (lcr_next[1:0] == 2'd0) begin
      res.stop_code = STOP_ONE_HALF;
    end else begin
      res.stop_code = STOP_TWO;
    end
    if (!lcr_next[3]) begin
      res.parity_code = PAR_NONE;
    end else if (!lcr_next[5]) begin
      res.parity_code = lcr_next[4] ? PAR_EVEN : PAR_ODD;
    end else begin
      res.parity_code = lcr_next[4] ? PAR_SPACE : PAR_MARK;
    end
  end

  // Commit state on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      div   <= DIV_RESET;
      lcr   <= LCR_RESET;
      ier   <= 4'd0;
      err   <= 2'd0;
      thre  <= 1'b0;
      mcr   <= 8'd0;
      msr   <= 8'd0;
      scr   <= 8'd0;
    end else if (go) begin
      head  <= head_next;
      count <= count_next;
      div   <= div_next;
      lcr   <= lcr_next;
      ier   <= ier_next;
      err   <= err_next;
      thre  <= thre_next;
      mcr   <= mcr_next;
      msr   <= msr_next;
      scr   <= scr_next;
    end
  end

  // Hold the reload divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_div <= DIV_RESET;
    end else if (cfg_we) begin
      dflt_div <= cfg_wdata;
    end
  end

  `include "uart_16550_register_block_core_assert.svh"

  `U16550_ASSERT_ALWAYS(a_count_bound, count <= DEPTH_C)
  `U16550_ASSERT_ALWAYS(a_pop_nonempty, !(go && res.rx_pop) || (count != '0))
  `U16550_ASSERT_NEXT(a_tx_sets_thre, go && res.tx_valid, thre)

endmodule

// ===== src/uart_16550_register_block_core.sv =====
// ----------------------------------------------------------------------------
// uart_16550_register_block_core
// 16550-style register block: register reads and writes and received
// characters in, one result per item out. Receive FIFO held in a memory.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake                     | Payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser req_type, tdata fields
// m_axis   | out | m_axis_tvalid / m_axis_tready | tdata result fields
// cfg      | in  | cfg_we                        | cfg_wdata default divisor
//
// One item per cycle sustained while the output does not stall; each result
// goes into the output register, the FIFO memory read landing on the same edge.
// rst clears control state synchronously; data and FIFO memory need no clearing.
// An input skid register takes one more item while the output stalls; that
// item is processed once the output frees.
// ----------------------------------------------------------------------------
module uart_16550_register_block_core
  import u16550_pkg::*;
#(
  parameter int RX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] reg_offset, [10:3] write_byte, [18:11] rx_char, [19] rx_parity_ok
  input  logic [23:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_byte, [8] irq_line, [9] tx_valid, [17:10] tx_byte,
  // [33:18] baud_divisor, [37:34] word_bits, [39:38] stop_code,
  // [42:40] parity_code
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int CW = $clog2(RX_DEPTH + 1);

  item_t port_item, skid_item, cur_item;
  logic  skid_valid;
  logic  go;
  res_t  res, s1;
  logic  s1_valid;

  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  logic [7:0]    mem_wr_data, mem_rd_data;

  // Unpack the input transfer
  always_comb begin
    port_item.req_type     = s_axis_tuser;
    port_item.reg_offset   = s_axis_tdata[2:0];
    port_item.write_byte   = s_axis_tdata[10:3];
    port_item.rx_char      = s_axis_tdata[18:11];
    port_item.rx_parity_ok = s_axis_tdata[19];
  end

  // Process from the skid register first; advance when the output frees
  assign s_axis_tready = !skid_valid;
  assign cur_item      = skid_valid ? skid_item : port_item;
  assign go            = (skid_valid || s_axis_tvalid) && (!s1_valid || m_axis_tready);

  // Park a transfer that cannot be processed this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (go) begin
        skid_valid <= 1'b0;
      end
    end else if (s_axis_tvalid && !go) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && s_axis_tvalid && !go) begin
      skid_item <= port_item;
    end
  end

  u16550_regs #(
    .DEPTH(RX_DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .item       (cur_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .res        (res),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr)
  );

  u16550_rx_mem #(
    .DEPTH(RX_DEPTH),
    .AW   (AW)
  ) u_rx_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  // Output register; drop the result once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (go) begin
      s1_valid <= 1'b1;
    end else if (m_axis_tready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1 <= res;
    end
  end

  // Pack the result; FIFO data joins from the memory read register
  assign m_axis_tvalid = s1_valid;
  assign m_axis_tdata  = {5'd0, s1.parity_code, s1.stop_code, s1.word_bits,
                          s1.baud_divisor, s1.tx_byte, s1.tx_valid, s1.irq_line,
                          (s1.rx_pop ? mem_rd_data : s1.read_byte)};

  `include "uart_16550_register_block_core_assert.svh"

  `U16550_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid || s1_valid)
  `U16550_ASSERT_NEXT(a_stall_holds, s1_valid && !m_axis_tready, s1_valid && $stable(m_axis_tdata))
  `U16550_ASSERT_NEXT(a_park_on_block, s_axis_tvalid && s_axis_tready && !go, skid_valid)

endmodule

// ===== test/uart_16550_register_block_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_16550_register_block_core_test
// Self-checking bench for the 16550 register block. Register reads, register
// writes and received characters go in on the input stream; an in-bench
// model of the register file predicts every result, and each output transfer
// is compared field by field with the oldest prediction. Random idle bursts
// on both streams, default-divisor changes between phases.
// ----------------------------------------------------------------------------
module uart_16550_register_block_core_test;
  import u16550_pkg::*;

  localparam int         CLK_HALF     = 10;
  localparam int         FIFO_DEPTH   = 16;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         RANDOM_ITEMS = 2000;
  localparam int         PHASES       = 8;
  localparam int         TAIL_CYCLES  = 4;
  localparam logic [1:0] REQ_NONE     = 2'd3;
  localparam logic [7:0] IIR_MST      = 8'h00;
  localparam logic [3:0] IRQ_RDA      = 4'b0001;
  localparam logic [3:0] IRQ_TX_EMPTY = 4'b0010;
  localparam logic [3:0] IRQ_RLS      = 4'b0100;
  localparam logic [3:0] IRQ_MST      = 4'b1000;
  localparam logic [7:0] FCR_CLEAR    = 8'h01 << FCR_RXCLR;
  localparam logic [7:0] DLAB_BIT     = 8'h01 << LCR_DIV_ACCESS;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        irq_line;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [15:0] baud_divisor;
    logic [3:0]  word_bits;
    logic [1:0]  stop_code;
    logic [2:0]  parity_code;
  } uart_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [2:0] reg_offset, [10:3] write_byte, [18:11] rx_char, [19] rx_parity_ok
  logic [23:0] s_axis_tdata = '0;
  // [1:0] req_type
  logic [1:0]  s_axis_tuser = REQ_READ;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] read_byte, [8] irq_line, [9] tx_valid, [17:10] tx_byte,
  // [33:18] baud_divisor, [37:34] word_bits, [39:38] stop_code,
  // [42:40] parity_code
  logic [47:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Bench control
  bit           idle_bursts = 1'b1;
  int           stall_left = 0;
  int           quiet_cycles = 0;
  int           mismatches = 0;
  int           random_items = 0;
  uart_result_t expected_results[$];

  // Register file shadow
  logic [7:0]  rx_bytes[FIFO_DEPTH];
  logic [3:0]  rx_oldest;
  int          rx_level;
  logic [15:0] div_latch;
  logic [15:0] default_div;
  logic [7:0]  lcr_shadow;
  logic [3:0]  ier_shadow;
  logic [3:0]  irq_flags;
  logic [1:0]  line_errors;
  logic [7:0]  thr_shadow;
  logic [7:0]  mcr_shadow;
  logic [7:0]  msr_shadow;
  logic [7:0]  scr_shadow;

  uart_16550_register_block_core #(
    .RX_DEPTH(FIFO_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Rebuild the pending flags from the FIFO and error state
  function automatic void update_pending();
    irq_flags = irq_flags & (IRQ_TX_EMPTY | IRQ_MST);
    if (line_errors != 2'b00) irq_flags = irq_flags | IRQ_RLS;
    if (rx_level != 0) irq_flags = irq_flags | IRQ_RDA;
  endfunction

  // A divisor that ends up zero falls back to the default, zero meaning one
  function automatic void reload_zero_divisor();
    if (div_latch == 16'd0) div_latch = (default_div == 16'd0) ? 16'd1 : default_div;
  endfunction

  function automatic void reset_shadow();
    rx_oldest   = '0;
    rx_level    = 0;
    default_div = DIV_RESET;
    div_latch   = DIV_RESET;
    lcr_shadow  = LCR_RESET;
    ier_shadow  = '0;
    irq_flags   = '0;
    line_errors = '0;
    thr_shadow  = '0;
    mcr_shadow  = '0;
    msr_shadow  = '0;
    scr_shadow  = '0;
  endfunction

  // Advance the shadow by one transfer and return the result it must give
  function automatic uart_result_t predict_uart_result(logic [1:0] req, logic [2:0] off,
                                                       logic [7:0] wb, logic [7:0] ch,
                                                       logic pok);
    uart_result_t r;
    logic         dlab;
    r    = '0;
    dlab = lcr_shadow[LCR_DIV_ACCESS];
    if (req == REQ_READ) begin
      case (off)
        REG_RBR: begin
          if (dlab) begin
            r.read_byte = div_latch[7:0];
          end else if (rx_level != 0) begin
            r.read_byte = rx_bytes[rx_oldest];
            rx_oldest   = rx_oldest + 4'd1;
            rx_level--;
          end
        end
        REG_IER: r.read_byte = dlab ? div_latch[15:8] : {4'b0, ier_shadow};
        REG_IIR: begin
          if (irq_flags & IRQ_RLS) begin
            r.read_byte = IIR_RLS;
          end else if (irq_flags & IRQ_RDA) begin
            r.read_byte = IIR_RDA;
          end else if (irq_flags & IRQ_TX_EMPTY) begin
            r.read_byte = IIR_TX_EMPTY;
            irq_flags   = irq_flags & ~IRQ_TX_EMPTY;
          end else if (irq_flags & IRQ_MST) begin
            r.read_byte = IIR_MST;
          end else begin
            r.read_byte = IIR_NONE;
          end
        end
        REG_LCR: r.read_byte = lcr_shadow;
        REG_MCR: r.read_byte = mcr_shadow;
        REG_LSR: begin
          r.read_byte = LSR_TX_IDLE | {5'b0, line_errors, rx_level != 0};
          line_errors = '0;
        end
        REG_MSR: r.read_byte = msr_shadow;
        default: r.read_byte = scr_shadow;
      endcase
    end else if (req == REQ_WRITE) begin
      case (off)
        REG_RBR: begin
          if (dlab) begin
            div_latch[7:0] = wb;
            reload_zero_divisor();
          end else begin
            thr_shadow = wb;
            r.tx_valid = 1'b1;
            r.tx_byte  = wb;
            irq_flags  = irq_flags | IRQ_TX_EMPTY;
          end
        end
        REG_IER: begin
          if (dlab) begin
            div_latch[15:8] = wb;
            reload_zero_divisor();
          end else begin
            ier_shadow = wb[3:0];
          end
        end
        // FCR sits at the IIR offset on writes
        REG_IIR: begin
          if (wb[FCR_RXCLR]) begin
            rx_level  = 0;
            rx_oldest = '0;
          end
        end
        REG_LCR: lcr_shadow = wb;
        REG_MCR: mcr_shadow = wb;
        REG_LSR: ;
        REG_MSR: msr_shadow = wb;
        default: scr_shadow = wb;
      endcase
    end else if (req == REQ_RX) begin
      // Drop the character on a full FIFO and flag overrun, parity unchecked
      if (rx_level < FIFO_DEPTH) begin
        rx_bytes[rx_oldest + 4'(rx_level)] = ch;
        rx_level++;
        if (!pok) line_errors[1] = 1'b1;
      end else begin
        line_errors[0] = 1'b1;
      end
    end
    update_pending();
    r.irq_line     = (irq_flags & ier_shadow) != 4'b0;
    r.baud_divisor = div_latch;
    r.word_bits    = 4'd5 + {2'b0, lcr_shadow[1:0]};
    if (!lcr_shadow[2]) r.stop_code = STOP_ONE;
    else r.stop_code = (lcr_shadow[1:0] != 2'b00) ? STOP_TWO : STOP_ONE_HALF;
    if (!lcr_shadow[3]) r.parity_code = PAR_NONE;
    else if (!lcr_shadow[5]) r.parity_code = lcr_shadow[4] ? PAR_EVEN : PAR_ODD;
    else r.parity_code = lcr_shadow[4] ? PAR_SPACE : PAR_MARK;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Byte with the extremes well represented
  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  // Drive one item, hold it until the transfer, then record its prediction
  task automatic send_item(input logic [1:0] req, input logic [2:0] off,
                           input logic [7:0] wb, input logic [7:0] ch, input logic pok);
    int gap;
    gap = 0;
    if (idle_bursts && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = req;
    s_axis_tdata  = {4'b0, pok, ch, wb, off};
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(predict_uart_result(req, off, wb, ch, pok));
  endtask

  // Hold off the sender until every predicted result has come out
  task automatic wait_for_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_default_divisor(input logic [15:0] value);
    wait_for_idle();
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we      = 1'b0;
    default_div = value;
  endtask

  // Program the divisor the usual way: DLAB on, DLL, DLM, DLAB off
  task automatic program_divisor(input logic [7:0] dll, input logic [7:0] dlm);
    logic [7:0] fmt;
    fmt = 8'($urandom) & ~DLAB_BIT;
    send_item(REQ_WRITE, REG_LCR, fmt | DLAB_BIT, 8'($urandom), 1'b1);
    send_item(REQ_WRITE, REG_RBR, dll, 8'($urandom), 1'b1);
    send_item(REQ_WRITE, REG_IER, dlm, 8'($urandom), 1'b1);
    send_item(REQ_WRITE, REG_LCR, fmt, 8'($urandom), 1'b1);
  endtask

  task automatic send_random_item(input int rx_pct);
    logic [1:0] req;
    logic [2:0] off;
    logic [7:0] wb;
    int         pick;
    pick = $urandom_range(0, 99);
    off  = 3'($urandom);
    wb   = rand_byte();
    if (pick < rx_pct) begin
      req = REQ_RX;
    end else if (pick < rx_pct + (100 - rx_pct) / 2) begin
      req = REQ_READ;
      if ($urandom_range(0, 1) == 0) off = REG_RBR;
    end else if (pick < 98) begin
      req = REQ_WRITE;
      if (off == REG_LCR) wb[LCR_DIV_ACCESS] = ($urandom_range(0, 3) == 0);
    end else begin
      req = REQ_NONE;
    end
    send_item(req, off, wb, rand_byte(), $urandom_range(0, 7) != 0);
    if (req != REQ_NONE && !(req == REQ_WRITE && off == REG_LSR)) random_items++;
  endtask

  task automatic test_register_defaults();
    // Every register after reset; an empty RBR reads zero
    for (int off = 0; off < 8; off++) send_item(REQ_READ, 3'(off), 8'h00, 8'h00, 1'b1);
    send_item(REQ_NONE, REG_SCR, 8'hff, 8'hff, 1'b0);
  endtask

  task automatic test_transmit_and_iir();
    send_item(REQ_WRITE, REG_IER, 8'hff, 8'h00, 1'b1);
    send_item(REQ_WRITE, REG_RBR, 8'hff, 8'h00, 1'b1);
    send_item(REQ_READ, REG_IIR, 8'h00, 8'h00, 1'b1);
  endtask

  task automatic test_receive_errors();
    send_item(REQ_RX, REG_RBR, 8'h00, 8'h00, 1'b1);
    send_item(REQ_RX, REG_RBR, 8'h00, 8'hff, 1'b0);
    send_item(REQ_READ, REG_IIR, 8'h00, 8'h00, 1'b1);
    send_item(REQ_READ, REG_LSR, 8'h00, 8'h00, 1'b1);
    send_item(REQ_READ, REG_RBR, 8'h00, 8'h00, 1'b1);
    send_item(REQ_WRITE, REG_IIR, FCR_CLEAR, 8'h00, 1'b1);
    send_item(REQ_READ, REG_RBR, 8'h00, 8'h00, 1'b1);
  endtask

  task automatic test_line_format_and_dlab();
    // DLAB with every format bit set, then divisor bytes through offsets 0 and 1
    send_item(REQ_WRITE, REG_LCR, 8'hff, 8'h00, 1'b1);
    send_item(REQ_WRITE, REG_RBR, 8'h00, 8'h00, 1'b1);
    send_item(REQ_WRITE, REG_IER, 8'hff, 8'h00, 1'b1);
    send_item(REQ_READ, REG_RBR, 8'h00, 8'h00, 1'b1);
    send_item(REQ_READ, REG_IER, 8'h00, 8'h00, 1'b1);
    // Five-bit words with the long stop bit
    send_item(REQ_WRITE, REG_LCR, 8'h04, 8'h00, 1'b1);
    send_item(REQ_WRITE, REG_LSR, 8'hff, 8'h00, 1'b1);
    send_item(REQ_WRITE, REG_MSR, 8'ha5, 8'h00, 1'b1);
    send_item(REQ_READ, REG_MSR, 8'h00, 8'h00, 1'b1);
  endtask

  task automatic test_divisor_reload();
    logic [15:0] defaults[4];
    defaults = '{16'd0, 16'd1, 16'hffff, 16'($urandom_range(2, 65534))};
    foreach (defaults[i]) begin
      write_default_divisor(defaults[i]);
      program_divisor(8'h00, 8'h00);
    end
  endtask

  task automatic test_fifo_overrun();
    // Fill past the top, then drain it completely
    wait_for_idle();
    send_item(REQ_WRITE, REG_IIR, FCR_CLEAR, 8'h00, 1'b1);
    for (int i = 0; i < FIFO_DEPTH + 2; i++)
      send_item(REQ_RX, REG_RBR, 8'h00, 8'($urandom), $urandom_range(0, 3) != 0);
    send_item(REQ_READ, REG_IIR, 8'h00, 8'h00, 1'b1);
    send_item(REQ_READ, REG_LSR, 8'h00, 8'h00, 1'b1);
    for (int i = 0; i < FIFO_DEPTH + 1; i++) send_item(REQ_READ, REG_RBR, 8'h00, 8'h00, 1'b1);
    random_items += 2 * FIFO_DEPTH + 6;
  endtask

  task automatic test_random_traffic();
    int rx_mix[3];
    int phase_end;
    rx_mix = '{20, 60, 35};
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase % 2 == 1) begin
        if (phase == 1) write_default_divisor(16'hffff);
        else if (phase == 3) write_default_divisor(16'd1);
        else write_default_divisor(16'($urandom_range(1, 65535)));
      end
      // The last phase runs with both streams always ready
      idle_bursts = (phase % 3 != 2) && (phase != PHASES - 1);
      phase_end   = RANDOM_ITEMS * (phase + 1) / PHASES;
      while (random_items < phase_end) begin
        if ($urandom_range(0, 39) == 0) begin
          program_divisor(rand_byte(), rand_byte());
          random_items += 4;
        end else begin
          send_random_item(rx_mix[phase % 3]);
        end
      end
    end
  endtask

  // Output stall bursts, changed on the falling edge
  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else if (idle_bursts && $urandom_range(0, 11) == 0) begin
      m_axis_tready = 1'b0;
      stall_left    = $urandom_range(0, 14);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    uart_result_t got;
    uart_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.read_byte    = m_axis_tdata[7:0];
      got.irq_line     = m_axis_tdata[8];
      got.tx_valid     = m_axis_tdata[9];
      got.tx_byte      = m_axis_tdata[17:10];
      got.baud_divisor = m_axis_tdata[33:18];
      got.word_bits    = m_axis_tdata[37:34];
      got.stop_code    = m_axis_tdata[39:38];
      got.parity_code  = m_axis_tdata[42:40];
      if (expected_results.size() == 0) begin
        $error("result transfer with no prediction waiting: 0x%0h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("read_byte", 16'(want.read_byte), 16'(got.read_byte));
        check_field("irq_line", 16'(want.irq_line), 16'(got.irq_line));
        check_field("tx_valid", 16'(want.tx_valid), 16'(got.tx_valid));
        check_field("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
        check_field("baud_divisor", want.baud_divisor, got.baud_divisor);
        check_field("word_bits", 16'(want.word_bits), 16'(got.word_bits));
        check_field("stop_code", 16'(want.stop_code), 16'(got.stop_code));
        check_field("parity_code", 16'(want.parity_code), 16'(got.parity_code));
      end
    end
  end

  // Abort when no transfer of any kind has happened for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    reset_shadow();
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_register_defaults();
    test_transmit_and_iir();
    test_receive_errors();
    test_line_format_and_dlab();
    test_divisor_reload();
    test_fifo_overrun();
    test_random_traffic();
    wait_for_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
